>>> sv/irw_pkg.sv
// irw_pkg: shared types and codes for the in-order retire instruction window.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package irw_pkg;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned RW_W   = 4;

  typedef enum logic [1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_RETIRE   = 2'd1,
    FUNC_COMPLETE = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]        func;
    logic              insert_ready;
    logic              has_addr;
    logic [ADDR_W-1:0] address;
    logic [TIME_W-1:0] issue_time;
  } req_t;

  typedef struct packed {
    logic              accepted;
    logic [3:0]        retired_count;
    logic              found;
    logic [TIME_W-1:0] min_depart;
    logic [CNT_W-1:0]  occupancy;
    logic              window_full;
  } rsp_t;
endpackage
`default_nettype wire

>>> sv/irw_if.sv
// irw_if: valid/ready channel carrying one payload.
// Depends on irw_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface irw_req_if;
  logic valid;
  logic ready;
  irw_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface irw_rsp_if;
  logic valid;
  logic ready;
  irw_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/inorder_retire_instruction_window.sv
// Instruction window with in-order retire; entries live in one synchronous RAM.
// Insert and unused code: the request passes S_DONE and S_OUT, then the result is valid.
// Retire: pops ready entries in order up to the limit; a not-ready entry stops it.
// Completion: reads every occupied entry and writes back each matching one as ready.
// One transfer in flight; next accepted once the result register is taken.
// Sync active-high reset: clears pointers and count, then sweeps the ready/addr bits
// of every entry before the first transfer. Depends on irw_pkg, irw_if.
`timescale 1ns / 1ps
`default_nettype none
module inorder_retire_instruction_window #(
  parameter int unsigned WINDOW_DEPTH = 128,
  parameter int unsigned MAX_RETIRE   = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [irw_pkg::RW_W-1:0] cfg_data,
  irw_req_if.sink   req,
  irw_rsp_if.source rsp
);
  localparam int unsigned PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned EW = 2 + irw_pkg::ADDR_W + irw_pkg::TIME_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_EVAL  = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  logic [EW-1:0] mem [WINDOW_DEPTH];
  logic [EW-1:0] rd_data;
  logic [PW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  state_t state;
  logic [PW-1:0] head_ptr, tail_ptr, idx;
  logic [irw_pkg::CNT_W+2:0] entry_count, scan;
  logic [irw_pkg::RW_W-1:0] retire_width;
  logic [4:0] retired;
  irw_pkg::req_t cur;
  irw_pkg::rsp_t res;
  logic rsp_valid;
  logic [4:0] limit;

  logic e_rdy, e_ha;
  logic [irw_pkg::ADDR_W-1:0] e_addr;
  logic [irw_pkg::TIME_W-1:0] e_dep;
  assign {e_rdy, e_ha, e_addr, e_dep} = rd_data;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (32'(p) == WINDOW_DEPTH - 1) ? '0 : p + PW'(1);
  endfunction

  assign limit = (32'(retire_width) > MAX_RETIRE) ? 5'(MAX_RETIRE) : 5'(retire_width);
  assign req.ready = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.data = res;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    rd_addr = idx;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_data = '0;
      end
      S_IDLE: begin
        wr_addr = head_ptr;
        wr_data = {req.data.insert_ready, req.data.has_addr, req.data.address,
                   req.data.issue_time};
        wr_en = req.valid && req.ready && (req.data.func == irw_pkg::FUNC_INSERT)
                && (32'(entry_count) < WINDOW_DEPTH);
      end
      S_EVAL: begin
        wr_en = (cur.func == irw_pkg::FUNC_COMPLETE) && e_ha && (e_addr == cur.address);
        wr_data = {1'b1, e_ha, e_addr, e_dep};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      head_ptr <= '0;
      tail_ptr <= '0;
      entry_count <= '0;
      retire_width <= irw_pkg::RW_W'(4);
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) retire_width <= cfg_data;
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          idx <= nxt(idx);
          if (32'(idx) == WINDOW_DEPTH - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.data;
            res.accepted <= 1'b0;
            res.retired_count <= '0;
            res.found <= 1'b0;
            res.min_depart <= '1;
            retired <= '0;
            scan <= '0;
            idx <= tail_ptr;
            state <= S_DONE;
            if (req.data.func == irw_pkg::FUNC_INSERT) begin
              if (32'(entry_count) < WINDOW_DEPTH) begin
                res.accepted <= 1'b1;
                head_ptr <= nxt(head_ptr);
                entry_count <= entry_count + 1'b1;
              end
            end else if (req.data.func == irw_pkg::FUNC_RETIRE ||
                         req.data.func == irw_pkg::FUNC_COMPLETE) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (cur.func == irw_pkg::FUNC_RETIRE) begin
            if (entry_count == '0 || retired >= limit) state <= S_DONE;
            else state <= S_EVAL;
          end else begin
            if (scan >= entry_count) state <= S_DONE;
            else state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_READ;
          if (cur.func == irw_pkg::FUNC_RETIRE) begin
            if (!e_rdy) state <= S_DONE;
            else begin
              tail_ptr <= nxt(tail_ptr);
              idx <= nxt(idx);
              entry_count <= entry_count - 1'b1;
              retired <= retired + 1'b1;
            end
          end else begin
            idx <= nxt(idx);
            scan <= scan + 1'b1;
            if (e_ha && e_addr == cur.address) begin
              res.found <= 1'b1;
              if (e_dep < res.min_depart) res.min_depart <= e_dep;
            end
          end
        end
        S_DONE: begin
          res.retired_count <= retired[3:0];
          res.occupancy <= irw_pkg::CNT_W'(entry_count);
          res.window_full <= (32'(entry_count) == WINDOW_DEPTH);
          state <= S_OUT;
        end
        S_OUT: begin
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(entry_count) <= WINDOW_DEPTH) else $error("count overflow");
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready) else $error("second transfer");
  a_ret_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (retired <= limit || cur.func != irw_pkg::FUNC_RETIRE))
    else $error("retire over limit");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && entry_count == '0) |-> (head_ptr == tail_ptr))
    else $error("pointers disagree");
`endif
endmodule
`default_nettype wire
